### design/lphm_pkg.sv
// shared types, constants and helpers for the linear probe hash map
package lphm_pkg;

   localparam int CAPACITY      = 64;
   localparam int IDX_W         = $clog2(CAPACITY);
   localparam int CNT_W         = $clog2(CAPACITY + 1);
   localparam int KEY_W         = 32;
   localparam int VAL_W         = 32;
   localparam int ENTRY_W       = KEY_W + VAL_W;
   localparam int ENTRY_COUNT_W = 7;

   // put is refused once occupied*4 >= capacity*3
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'((3 * CAPACITY + 3) / 4);

   typedef enum logic [1:0] {
      CMD_PUT    = 2'd0,
      CMD_GET    = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_INVALID   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FIND,
      S_RM_SCAN,
      S_RM_PLACE,
      S_DONE
   } state_type;

   typedef struct packed {
      cmd_type            command;
      logic [KEY_W-1:0]   key;
      logic [VAL_W-1:0]   value;
   } req_word_type;

   typedef struct packed {
      status_type                 status;
      logic [VAL_W-1:0]           value_out;
      logic [ENTRY_COUNT_W-1:0]   entry_count;
   } rsp_word_type;

   function automatic logic [IDX_W-1:0] home_slot(input logic [KEY_W-1:0] k);
      return k[IDX_W-1:0];
   endfunction

endpackage

### design/lphm_ram.sv
// single write, single read synchronous ram with write-first forwarding
module lphm_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 64,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // same-address read in the write cycle sees the new data
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/lphm_ctrl.sv
// command sequencer: probing, update, removal with run reinsertion, slot valid bits
module lphm_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  lphm_pkg::req_word_type          req_word,
   output logic                            res_valid,
   input  logic                            res_ready,
   output lphm_pkg::rsp_word_type          res_word,
   output logic                            ram_wr_en,
   output logic [lphm_pkg::IDX_W-1:0]      ram_wr_addr,
   output logic [lphm_pkg::ENTRY_W-1:0]    ram_wr_data,
   output logic [lphm_pkg::IDX_W-1:0]      ram_rd_addr,
   input  logic [lphm_pkg::ENTRY_W-1:0]    ram_rd_data
);
   import lphm_pkg::*;

   state_type             state_ff, state_in;
   cmd_type               cmd_ff, cmd_in;
   logic [KEY_W-1:0]      key_ff, key_in;
   logic [VAL_W-1:0]      value_ff, value_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [IDX_W-1:0]      pl_ff, pl_in;
   logic [KEY_W-1:0]      mv_key_ff, mv_key_in;
   logic [VAL_W-1:0]      mv_val_ff, mv_val_in;
   logic [CNT_W-1:0]      occ_ff, occ_in;
   logic [CAPACITY-1:0]   valid_ff, valid_in;
   status_type            status_ff, status_in;
   logic [VAL_W-1:0]      vout_ff, vout_in;

   logic [KEY_W-1:0]      rd_key;
   logic [VAL_W-1:0]      rd_val;
   logic                  cur_valid;
   logic                  hit;
   logic                  pl_free;
   logic                  accept;
   logic                  put_full;

   assign rd_key    = ram_rd_data[ENTRY_W-1:VAL_W];
   assign rd_val    = ram_rd_data[VAL_W-1:0];
   assign cur_valid = valid_ff[idx_ff];
   assign hit       = cur_valid && (rd_key == key_ff);
   assign pl_free   = !valid_ff[pl_ff];
   assign accept    = req_valid && req_ready;
   assign put_full  = (req_word.command == CMD_PUT) && (occ_ff >= FULL_COUNT);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               priority if (req_word.command == CMD_CLEAR) state_in = S_DONE;
               else if (req_word.key == '0)               state_in = S_DONE;
               else if (put_full)                          state_in = S_DONE;
               else                                        state_in = S_FIND;
            end
         end
         S_FIND: begin
            if (!cur_valid) begin
               state_in = S_DONE;
            end else if (hit) begin
               state_in = (cmd_ff == CMD_REMOVE) ? S_RM_SCAN : S_DONE;
            end
         end
         S_RM_SCAN: begin
            state_in = cur_valid ? S_RM_PLACE : S_DONE;
         end
         S_RM_PLACE: begin
            if (pl_free) state_in = S_RM_SCAN;
         end
         S_DONE: begin
            if (res_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_ready   = (state_ff == S_IDLE);
      res_valid   = (state_ff == S_DONE);
      res_word    = '{status: status_ff, value_out: vout_ff,
                      entry_count: ENTRY_COUNT_W'(occ_ff)};
      ram_wr_en   = 1'b0;
      ram_wr_addr = idx_ff;
      ram_wr_data = {key_ff, value_ff};
      ram_rd_addr = idx_ff + IDX_W'(1);
      cmd_in      = cmd_ff;
      key_in      = key_ff;
      value_in    = value_ff;
      idx_in      = idx_ff;
      pl_in       = pl_ff;
      mv_key_in   = mv_key_ff;
      mv_val_in   = mv_val_ff;
      occ_in      = occ_ff;
      valid_in    = valid_ff;
      status_in   = status_ff;
      vout_in     = vout_ff;

      unique case (state_ff)
         S_IDLE: begin
            ram_rd_addr = home_slot(req_word.key);
            if (accept) begin
               cmd_in    = req_word.command;
               key_in    = req_word.key;
               value_in  = req_word.value;
               idx_in    = home_slot(req_word.key);
               vout_in   = '0;
               status_in = ST_OK;
               priority if (req_word.command == CMD_CLEAR) begin
                  valid_in = '0;
                  occ_in   = '0;
               end else if (req_word.key == '0) begin
                  status_in = ST_INVALID;
               end else if (put_full) begin
                  status_in = ST_FULL;
               end
            end
         end
         S_FIND: begin
            if (!cur_valid) begin
               // empty slot ends the probe
               if (cmd_ff == CMD_PUT) begin
                  ram_wr_en        = 1'b1;
                  valid_in[idx_ff] = 1'b1;
                  occ_in           = occ_ff + CNT_W'(1);
               end else begin
                  status_in = ST_NOT_FOUND;
               end
            end else if (hit) begin
               unique case (cmd_ff)
                  CMD_PUT:    ram_wr_en = 1'b1;
                  CMD_GET:    vout_in = rd_val;
                  CMD_REMOVE: begin
                     valid_in[idx_ff] = 1'b0;
                     occ_in           = occ_ff - CNT_W'(1);
                     idx_in           = idx_ff + IDX_W'(1);
                  end
                  CMD_CLEAR:  vout_in = vout_ff;
               endcase
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         S_RM_SCAN: begin
            ram_rd_addr = idx_ff;
            if (cur_valid) begin
               // lift the entry out and search for its new slot
               mv_key_in        = rd_key;
               mv_val_in        = rd_val;
               valid_in[idx_ff] = 1'b0;
               occ_in           = occ_ff - CNT_W'(1);
               pl_in            = home_slot(rd_key);
            end
         end
         S_RM_PLACE: begin
            ram_wr_addr = pl_ff;
            ram_wr_data = {mv_key_ff, mv_val_ff};
            if (pl_free) begin
               ram_wr_en       = 1'b1;
               valid_in[pl_ff] = 1'b1;
               occ_in          = occ_ff + CNT_W'(1);
               idx_in          = idx_ff + IDX_W'(1);
            end else begin
               pl_in = pl_ff + IDX_W'(1);
            end
         end
         S_DONE: begin
            ram_rd_addr = idx_ff;
         end
         default: begin
            ram_rd_addr = idx_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         occ_ff   <= '0;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         occ_ff   <= occ_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      key_ff    <= key_in;
      value_ff  <= value_in;
      idx_ff    <= idx_in;
      pl_ff     <= pl_in;
      mv_key_ff <= mv_key_in;
      mv_val_ff <= mv_val_in;
      status_ff <= status_in;
      vout_ff   <= vout_in;
   end

endmodule

### design/linear_probe_hash_map_top.sv
// top level of the linear probe hash map: sequencer, entry ram and result register
// usage
//   req channel carries one command word (put, get, remove, clear) with key and value;
//   rsp channel returns one word per command: status, value found by get, entry count
//   commands are taken one at a time: req_ready is high while the sequencer is idle
// timing
//   the home slot is read on the accepting edge, then one slot is probed per cycle
//   put/get: slots are probed until a hit or an empty slot, then the result register loads once free
//   remove: as get, then every entry following in the run is lifted out in a scan step
//     and placed by probing from its home slot to the first free slot found;
//     a last scan step finds the end of the run
//   clear, zero key, refused put: answered straight from idle, with no probe
//   the slot probe rate is set by the single read port of the entry ram
// reset
//   all slot valid bits clear on reset, so the table is empty straight after reset;
//   no sweep through the ram is needed, the entry data is only read at valid slots
// stalls
//   the result waits in the output register; the next command can be accepted and
//   worked on meanwhile, only its hand-over waits until the register is free
module linear_probe_hash_map_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  lphm_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output lphm_pkg::rsp_word_type rsp_word
);
   import lphm_pkg::*;

   // sequencer to result register
   logic         res_valid;
   logic         res_ready;
   rsp_word_type res_word;

   // entry ram port: {key, value} per slot
   logic               ram_wr_en;
   logic [IDX_W-1:0]   ram_wr_addr;
   logic [ENTRY_W-1:0] ram_wr_data;
   logic [IDX_W-1:0]   ram_rd_addr;
   logic [ENTRY_W-1:0] ram_rd_data;

   // output register
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   lphm_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_word    (req_word),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res_word    (res_word),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   lphm_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (ENTRY_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // register is free when empty or being drained this cycle
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         if (res_valid) rsp_word_in = res_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

`ifndef SYNTHESIS
   // one command at a time: busy straight after a word is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("req_ready high the cycle after an accept");

   // the load limit keeps the count at or below the full threshold
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word.entry_count <= ENTRY_COUNT_W'(FULL_COUNT)))
      else $error("entry count above load limit");

   // a refused put only happens at the threshold
   a_full_at_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_word.status == ST_FULL))
      |-> (rsp_word.entry_count == ENTRY_COUNT_W'(FULL_COUNT)))
      else $error("full status below load limit");

   // value is only returned with an ok status
   a_value_only_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_word.status != ST_OK)) |-> (rsp_word.value_out == '0))
      else $error("nonzero value with failing status");
`endif

endmodule

### tb/sv/testbench.sv
// self-checking testbench for the linear probe hash map: command driver, shadow table, word checker
`timescale 1ns / 100ps

module testbench;
   import lphm_pkg::*;

   // cycles without any accepted word before the run is declared hung; the slowest
   // correct command is a remove that reinserts a long run
   localparam int HANG_LIMIT   = 20000;
   // trailing cycles once every result is in
   localparam int TAIL_CYCLES  = 50;
   // backlog size below which neither side idles any more
   localparam int CALM_ITEMS   = 150;
   localparam int RANDOM_ITEMS = 1600;

   // one queued command word, optionally held back until the map has answered everything
   typedef struct {
      bit           drain_first;
      req_word_type word;
   } backlog_entry_type;

   logic         clock;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_word_type req_word  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_word;

   backlog_entry_type cmd_backlog[$];
   rsp_word_type      awaited_rsp[$];

   // shadow copy of the table
   logic [KEY_W-1:0] map_keys[CAPACITY];
   logic [VAL_W-1:0] map_vals[CAPACITY];
   int               map_count = 0;

   int  fail_count = 0;
   int  rsp_seen   = 0;
   bit  calm_phase = 1'b0;

   // driver idling state
   int  drv_gap     = 0;
   int  drv_stretch = 0;
   bit  drv_idle_on = 1'b0;
   // receiver stall state
   int  mon_stall   = 0;
   int  mon_stretch = 0;
   bit  mon_idle_on = 1'b0;

   linear_probe_hash_map_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // shadow table
   // ---------------------------------------------------------------------------

   // walk from the home slot until the key or an empty slot turns up
   function automatic bit find_key(input logic [KEY_W-1:0] k, output int slot);
      int idx;
      slot = 0;
      idx  = int'(k[IDX_W-1:0]);
      for (int n = 0; n < CAPACITY; n++) begin
         if (map_keys[idx] == '0)
            return 1'b0;
         if (map_keys[idx] == k) begin
            slot = idx;
            return 1'b1;
         end
         idx = (idx + 1) % CAPACITY;
      end
      return 1'b0;
   endfunction

   // first free slot from the home slot; the load limit guarantees one exists
   function automatic void store_entry(input logic [KEY_W-1:0] k, input logic [VAL_W-1:0] v);
      int idx;
      idx = int'(k[IDX_W-1:0]);
      for (int n = 0; n < CAPACITY; n++) begin
         if (map_keys[idx] == '0) begin
            map_keys[idx] = k;
            map_vals[idx] = v;
            map_count++;
            return;
         end
         idx = (idx + 1) % CAPACITY;
      end
   endfunction

   // applies one command word to the shadow table and returns the word the map owes
   function automatic rsp_word_type hash_map_result(input req_word_type w);
      rsp_word_type     r;
      int               slot;
      int               nxt;
      logic [KEY_W-1:0] k;
      logic [VAL_W-1:0] v;
      r.status    = ST_OK;
      r.value_out = '0;
      if (w.command == CMD_CLEAR) begin
         // key and value are ignored
         for (int i = 0; i < CAPACITY; i++)
            map_keys[i] = '0;
         map_count = 0;
      end else if (w.key == '0) begin
         r.status = ST_INVALID;
      end else if (w.command == CMD_PUT) begin
         // refused at 75% load, even when it would only update
         if (map_count * 4 >= CAPACITY * 3)
            r.status = ST_FULL;
         else if (find_key(w.key, slot))
            map_vals[slot] = w.value;
         else
            store_entry(w.key, w.value);
      end else if (w.command == CMD_GET) begin
         if (map_count != 0 && find_key(w.key, slot))
            r.value_out = map_vals[slot];
         else
            r.status = ST_NOT_FOUND;
      end else begin
         if (map_count == 0 || !find_key(w.key, slot)) begin
            r.status = ST_NOT_FOUND;
         end else begin
            map_keys[slot] = '0;
            map_count--;
            // pull out and reinsert the rest of the run
            nxt = (slot + 1) % CAPACITY;
            for (int n = 0; n < CAPACITY && map_keys[nxt] != '0; n++) begin
               k = map_keys[nxt];
               v = map_vals[nxt];
               map_keys[nxt] = '0;
               map_count--;
               store_entry(k, v);
               nxt = (nxt + 1) % CAPACITY;
            end
         end
      end
      r.entry_count = ENTRY_COUNT_W'(map_count);
      return r;
   endfunction

   task automatic flag_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
      fail_count++;
      $display("mismatch on result word %0d, %s: got %0h, want %0h",
               rsp_seen, what, got, want);
   endtask

   // ---------------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------------

   function automatic void queue_cmd(input cmd_type c, input logic [KEY_W-1:0] k,
                                     input logic [VAL_W-1:0] v, input bit drain);
      backlog_entry_type e;
      e.drain_first  = drain;
      e.word.command = c;
      e.word.key     = k;
      e.word.value   = v;
      cmd_backlog.push_back(e);
   endfunction

   initial begin : stimulus
      logic [KEY_W-1:0] key_pool[CAPACITY];
      logic [KEY_W-1:0] k;
      logic [VAL_W-1:0] v;
      logic [IDX_W-1:0] spread;
      logic [IDX_W-1:0] base;
      int               made;
      int               pool_n;
      int               ep_len;
      int               put_pct;
      int               r;
      cmd_type          c;

      for (int i = 0; i < CAPACITY; i++) begin
         map_keys[i] = '0;
         map_vals[i] = '0;
      end

      // directed: empty table, zero key, wrap round the end of the table,
      // run compaction on remove, update in place, clear
      queue_cmd(CMD_GET,    32'h0000_0001, 32'h0,         1'b0);
      queue_cmd(CMD_REMOVE, 32'h0000_0001, 32'h0,         1'b0);
      queue_cmd(CMD_PUT,    32'h0,         32'hDEAD_BEEF, 1'b0);
      queue_cmd(CMD_GET,    32'h0,         32'h0,         1'b0);
      queue_cmd(CMD_REMOVE, 32'h0,         32'h0,         1'b0);
      queue_cmd(CMD_CLEAR,  32'h0,         32'hFFFF_FFFF, 1'b0);
      queue_cmd(CMD_PUT,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      queue_cmd(CMD_PUT,    32'h0000_007F, 32'h1234_5678, 1'b0);
      queue_cmd(CMD_PUT,    32'h0000_0040, 32'h0,         1'b0);
      queue_cmd(CMD_PUT,    32'h0000_0001, 32'h8000_0000, 1'b0);
      queue_cmd(CMD_GET,    32'h0000_007F, 32'h0,         1'b0);
      queue_cmd(CMD_GET,    32'h0000_0040, 32'h0,         1'b0);
      queue_cmd(CMD_PUT,    32'h0000_007F, 32'h0,         1'b0);
      queue_cmd(CMD_REMOVE, 32'hFFFF_FFFF, 32'h0,         1'b0);
      queue_cmd(CMD_GET,    32'h0000_007F, 32'h0,         1'b0);
      queue_cmd(CMD_GET,    32'h0000_0040, 32'h0,         1'b0);
      queue_cmd(CMD_GET,    32'h0000_0001, 32'h0,         1'b0);
      queue_cmd(CMD_REMOVE, 32'h0000_013F, 32'h0,         1'b0);
      queue_cmd(CMD_GET,    32'hFFFF_FFFF, 32'h0,         1'b0);
      queue_cmd(CMD_REMOVE, 32'h0000_0040, 32'h0,         1'b1);
      queue_cmd(CMD_GET,    32'h0000_0001, 32'h0,         1'b0);
      queue_cmd(CMD_CLEAR,  $urandom,      $urandom,      1'b0);
      queue_cmd(CMD_GET,    32'h0000_0001, 32'h0,         1'b0);
      queue_cmd(CMD_PUT,    32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
      queue_cmd(CMD_GET,    32'h8000_0000, 32'h0,         1'b0);

      // random: episodes over a pool of keys, mostly clustered round a few home slots,
      // so runs form, the load limit is hit and removes have runs to compact
      made = 0;
      while (made < RANDOM_ITEMS) begin
         pool_n = ($urandom_range(0, 3) == 0) ? $urandom_range(48, CAPACITY)
                                              : $urandom_range(4, 40);
         case ($urandom_range(0, 3))
            0:       spread = '0;
            1:       spread = IDX_W'(3);
            2:       spread = IDX_W'(15);
            default: spread = '1;
         endcase
         base = IDX_W'($urandom);
         for (int i = 0; i < pool_n; i++) begin
            k = $urandom;
            case ($urandom_range(0, 7))
               0: k[KEY_W-1:IDX_W] = '1;
               1: k[KEY_W-1:IDX_W] = '0;
               default: ;
            endcase
            k[IDX_W-1:0] = base + (IDX_W'($urandom) & spread);
            if (k == '0)
               k = KEY_W'(CAPACITY);
            key_pool[i] = k;
         end
         ep_len = $urandom_range(30, 160);
         for (int j = 0; j < ep_len; j++) begin
            // fill first, then a mixture
            put_pct = (j < ep_len / 3) ? 80 : 40;
            k = key_pool[$urandom_range(0, pool_n - 1)];
            v = $urandom;
            case ($urandom_range(0, 9))
               0: v = '0;
               1: v = '1;
               default: ;
            endcase
            r = $urandom_range(0, 99);
            if (r < put_pct)
               c = CMD_PUT;
            else if (r < put_pct + (100 - put_pct) / 2)
               c = CMD_GET;
            else
               c = CMD_REMOVE;
            r = $urandom_range(0, 199);
            if (r < 3)
               c = CMD_CLEAR;
            else if (r < 8)
               k = '0;
            else if (r < 14)
               k = $urandom;
            queue_cmd(c, k, v, j == 0 && made < RANDOM_ITEMS - 2 * CALM_ITEMS &&
                               $urandom_range(0, 2) == 0);
            made++;
         end
         if ($urandom_range(0, 2) == 0) begin
            queue_cmd(CMD_CLEAR, $urandom, $urandom, 1'b0);
            made++;
         end
      end

      // shadow table starts out empty again for the run proper
      for (int i = 0; i < CAPACITY; i++)
         map_keys[i] = '0;
      map_count = 0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // everything sent and answered, then a short tail for stray words
      while (!(cmd_backlog.size() == 0 && !req_valid && awaited_rsp.size() == 0))
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // command driver
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : drive
      logic              next_valid;
      req_word_type      next_word;
      backlog_entry_type e;
      if (reset) begin
         req_valid <= 1'b0;
         req_word  <= '0;
      end else begin
         next_valid = req_valid;
         next_word  = req_word;
         // word taken at this edge: predict its answer in acceptance order
         if (req_valid && req_ready) begin
            awaited_rsp.push_back(hash_map_result(req_word));
            next_valid = 1'b0;
         end
         // stretches with and without idling
         if (drv_stretch == 0) begin
            drv_stretch = $urandom_range(20, 200);
            drv_idle_on = ($urandom_range(0, 2) != 0);
         end else begin
            drv_stretch--;
         end
         if (!next_valid) begin
            if (drv_gap > 0) begin
               drv_gap--;
            end else if (drv_idle_on && !calm_phase && $urandom_range(0, 4) == 0) begin
               drv_gap = $urandom_range(0, 8);
            end else if (cmd_backlog.size() > 0) begin
               // a marked word waits until the map owes nothing; rsp_valid here is the
               // value before this edge, so the hold does not hang on block order
               if (!(cmd_backlog[0].drain_first && (awaited_rsp.size() != 0 || rsp_valid)))
               begin
                  e          = cmd_backlog.pop_front();
                  next_valid = 1'b1;
                  next_word  = e.word;
               end
            end
         end
         calm_phase <= (cmd_backlog.size() < CALM_ITEMS);
         req_valid  <= next_valid;
         req_word   <= next_word;
      end
   end

   // ---------------------------------------------------------------------------
   // result checker
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : observe
      rsp_word_type want;
      logic         next_ready;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_rsp.size() == 0) begin
               flag_mismatch("word with nothing outstanding", 64'(rsp_word), 64'h0);
            end else begin
               want = awaited_rsp.pop_front();
               if (rsp_word.status !== want.status)
                  flag_mismatch("status", 64'(rsp_word.status), 64'(want.status));
               if (rsp_word.value_out !== want.value_out)
                  flag_mismatch("value_out", 64'(rsp_word.value_out), 64'(want.value_out));
               if (rsp_word.entry_count !== want.entry_count)
                  flag_mismatch("entry_count", 64'(rsp_word.entry_count),
                                64'(want.entry_count));
            end
            rsp_seen++;
         end
         if (mon_stretch == 0) begin
            mon_stretch = $urandom_range(20, 200);
            mon_idle_on = ($urandom_range(0, 2) != 0);
         end else begin
            mon_stretch--;
         end
         // stalls come in bursts regardless of whether a word is waiting
         next_ready = 1'b1;
         if (mon_stall > 0) begin
            mon_stall--;
            next_ready = 1'b0;
         end else if (mon_idle_on && !calm_phase && $urandom_range(0, 5) == 0) begin
            mon_stall  = $urandom_range(0, 8);
            next_ready = 1'b0;
         end
         rsp_ready <= next_ready;
      end
   end

   // ---------------------------------------------------------------------------
   // watchdog: any accepted word on either side counts as progress
   // ---------------------------------------------------------------------------
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < HANG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
